// ----- src/bitmap_row_rotate_scroll_unit_defines.svh -----
// ----------------------------------------------------------------------------
// bitmap_row_rotate_scroll_unit_defines.svh
// Assertion macros for the bitmap row rotate / scroll unit.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ROW_ROTATE_SCROLL_UNIT_DEFINES_SVH
`define BITMAP_ROW_ROTATE_SCROLL_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define BRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/brs_pkg.sv -----
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types and constants of the bitmap row rotate / scroll unit.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int unsigned TILE_ROWS = 16;
  localparam int unsigned MAX_SHIFT = 8;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_READ   = 2'd1,
    REQ_SCR_RT = 2'd2,
    REQ_SCR_LT = 2'd3
  } brs_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FIN
  } brs_state_t;

  // kicks off one full-bitmap rotate
  typedef struct packed {
    logic       start;
    logic       to_right;
    logic [3:0] amount;
  } brs_scroll_cmd_t;

endpackage

// ----- src/brs_ram.sv -----
// ----------------------------------------------------------------------------
// brs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module brs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/brs_scroll.sv -----
// ----------------------------------------------------------------------------
// brs_scroll
// Scan engine: walks every line, reads each byte (the wrap byte twice), writes it rotated.
// ----------------------------------------------------------------------------
module brs_scroll #(
  parameter int COLS  = 16,
  parameter int LINES = 128
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  brs_pkg::brs_scroll_cmd_t                cmd,
  output logic                                    done,
  output logic                                    rd_en,
  output logic [$clog2(LINES)+$clog2(COLS)-1:0]   rd_addr,
  input  logic [7:0]                              rd_data,
  output logic                                    wr_en,
  output logic [$clog2(LINES)+$clog2(COLS)-1:0]   wr_addr,
  output logic [7:0]                              wr_data
);
  import brs_pkg::*;

  localparam int CW = $clog2(COLS);
  localparam int LW = $clog2(LINES);
  localparam int AW = LW + CW;
  localparam logic [CW-1:0] LAST_COL  = CW'(COLS - 1);
  localparam logic [LW-1:0] LAST_LINE = LW'(LINES - 1);

  // Right rotate scans columns upward with the last byte pre-read;
  // left rotate scans downward with byte 0 pre-read. The pre-read byte
  // is rewritten last, so every read sees the old value.
  function automatic logic [7:0] rot(input logic [7:0] nb, input logic [7:0] cur,
                                     input logic right, input logic [3:0] p);
    logic [15:0] t;
    if (right) begin
      t = {nb, cur} >> p;
      rot = t[7:0];
    end else begin
      t = {cur, nb} << p;
      rot = t[15:8];
    end
  endfunction

  logic          active;
  logic          to_right;
  logic [3:0]    amt;
  logic [LW-1:0] line_cnt;
  logic [CW-1:0] col_cnt;
  logic          pre;
  logic          s1_valid;
  logic          s1_pre;
  logic [AW-1:0] s1_addr;
  logic [7:0]    prev;
  logic [CW-1:0] edge_col;

  assign edge_col = to_right ? LAST_COL : '0;
  assign rd_en    = active;
  assign rd_addr  = {line_cnt, pre ? edge_col : col_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      s1_valid <= 1'b0;
      pre      <= 1'b1;
    end else begin
      s1_valid <= active;
      if (cmd.start) begin
        active   <= 1'b1;
        to_right <= cmd.to_right;
        amt      <= cmd.amount;
        line_cnt <= '0;
        pre      <= 1'b1;
      end else if (active) begin
        if (pre) begin
          pre     <= 1'b0;
          col_cnt <= to_right ? '0 : LAST_COL;
        end else if (col_cnt == edge_col) begin
          pre <= 1'b1;
          if (line_cnt == LAST_LINE) begin
            active <= 1'b0;
          end else begin
            line_cnt <= line_cnt + 1'b1;
          end
        end else begin
          col_cnt <= to_right ? col_cnt + 1'b1 : col_cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pre  <= pre;
    s1_addr <= rd_addr;
    if (s1_valid) begin
      prev <= rd_data;
    end
  end

  assign wr_en   = s1_valid && !s1_pre;
  assign wr_addr = s1_addr;
  assign wr_data = rot(prev, rd_data, to_right, amt);
  assign done    = s1_valid && !active;

endmodule

// ----- src/bitmap_row_rotate_scroll_unit.sv -----
// ----------------------------------------------------------------------------
// bitmap_row_rotate_scroll_unit
// 1bpp bitmap store with byte load/read and whole-bitmap horizontal rotate.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | words
// req     | in  | req_valid/req_stall  | req_type line_index column_byte pixel_byte
//         |     |                      | shift_amount
// rsp     | out | rsp_valid/rsp_stall  | read_byte is_read_reply
//
// Load goes straight to ST_FIN; read passes through ST_READ for the registered RAM read.
// Scroll does one RAM read per byte plus one pre-read of the wrap byte per line,
// through the single read port.
// One item in flight; a new word is taken while the last reply waits on rsp_stall.
// rst is synchronous; bitmap contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "bitmap_row_rotate_scroll_unit_defines.svh"

module bitmap_row_rotate_scroll_unit #(
  parameter int COLS       = 16,
  parameter int TILE_LINES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] req_type,
  input  logic [6:0] line_index,
  input  logic [3:0] column_byte,
  input  logic [7:0] pixel_byte,
  input  logic [3:0] shift_amount,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_byte,
  output logic       is_read_reply
);
  import brs_pkg::*;

  localparam int LINES = TILE_ROWS * TILE_LINES;
  localparam int CW    = $clog2(COLS);
  localparam int LW    = $clog2(LINES);
  localparam int AW    = LW + CW;
  localparam logic [8:0] LINES_C = 9'(LINES);
  localparam logic [6:0] COLS_C  = 7'(COLS);

  brs_state_t      state, state_next;
  brs_scroll_cmd_t cmd;

  logic          acc;
  logic          in_range;
  logic [AW-1:0] req_addr;
  logic [3:0]    amt_sat;
  logic          rd_ok;
  logic [7:0]    res_byte;
  logic          res_reply;
  logic          out_free;

  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]    ram_wr_data, ram_rd_data;

  logic          scan_done, scan_rd_en, scan_wr_en;
  logic [AW-1:0] scan_rd_addr, scan_wr_addr;
  logic [7:0]    scan_wr_data;

  assign acc       = req_valid && (state == ST_IDLE);
  assign req_stall = (state != ST_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign in_range  = ({2'b00, line_index} < LINES_C) && ({3'b000, column_byte} < COLS_C);
  assign req_addr  = {LW'(line_index), CW'(column_byte)};
  assign amt_sat   = (shift_amount > 4'(MAX_SHIFT)) ? 4'(MAX_SHIFT) : shift_amount;

  assign cmd.start    = acc && (req_type == REQ_SCR_RT || req_type == REQ_SCR_LT);
  assign cmd.to_right = (req_type == REQ_SCR_RT);
  assign cmd.amount   = amt_sat;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (req_type)
            REQ_LOAD:               state_next = ST_FIN;
            REQ_READ:               state_next = ST_READ;
            REQ_SCR_RT, REQ_SCR_LT: state_next = ST_SCAN;
            default:                state_next = ST_FIN;
          endcase
        end
      end
      ST_READ: state_next = ST_FIN;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIN && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_ok     <= in_range;
      res_byte  <= '0;
      res_reply <= (req_type == REQ_READ);
    end
    if (state == ST_READ) begin
      res_byte <= rd_ok ? ram_rd_data : 8'h00;
    end
    if (state == ST_FIN && out_free) begin
      read_byte     <= res_byte;
      is_read_reply <= res_reply;
    end
  end

  // scan engine owns the RAM while scrolling
  always_comb begin
    if (state == ST_SCAN) begin
      ram_wr_en   = scan_wr_en;
      ram_wr_addr = scan_wr_addr;
      ram_wr_data = scan_wr_data;
      ram_rd_en   = scan_rd_en;
      ram_rd_addr = scan_rd_addr;
    end else begin
      ram_wr_en   = acc && (req_type == REQ_LOAD) && in_range;
      ram_wr_addr = req_addr;
      ram_wr_data = pixel_byte;
      ram_rd_en   = acc && (req_type == REQ_READ);
      ram_rd_addr = req_addr;
    end
  end

  brs_ram #(
    .WIDTH (8),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  brs_scroll #(
    .COLS  (COLS),
    .LINES (LINES)
  ) u_scroll (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .done    (scan_done),
    .rd_en   (scan_rd_en),
    .rd_addr (scan_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (scan_wr_en),
    .wr_addr (scan_wr_addr),
    .wr_data (scan_wr_data)
  );

  `BRS_ASSERT_NOW(a_no_rw_same_addr, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
                  "RAM read and write hit the same entry")
  `BRS_ASSERT_NOW(a_done_in_scan, scan_done, state == ST_SCAN,
                  "scan done outside a scroll")
  `BRS_ASSERT_NEXT(a_fin_replies, state == ST_FIN && out_free, rsp_valid,
                   "finished word not presented")
  `BRS_ASSERT_NOW(a_zero_non_read, rsp_valid && !is_read_reply, read_byte == 8'h00,
                  "non-read reply carries data")

endmodule
